// ----- design/cft_pkg.sv -----
// ----------------------------------------------------------------------------
// cft_pkg: shared types for the cancellable FIFO task queue
// Word layouts for the request and response channels, the operation and
// status codes, the stored entry layout and the default queue depth.
// ----------------------------------------------------------------------------
package cft_pkg;

   // default number of entries the queue holds
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

   // operation codes carried in a request word
   typedef enum logic [1:0] {
      MODE_ADMIT  = 2'd0,
      MODE_SELECT = 2'd1,
      MODE_REVOKE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   // completion codes carried in a response word
   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_MISS    = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_NO_TASK = 2'd3
   } status_type;

   // request word
   typedef struct packed {
      mode_type    mode;
      logic        task_present;
      logic [15:0] task_handle;
      logic [31:0] request_key;
      logic [15:0] model_tag;
   } req_word_type;

   // response word
   typedef struct packed {
      status_type  status;
      logic [15:0] out_task_handle;
      logic [15:0] out_model_tag;
      logic        cancel_signal;
      logic [4:0]  pending_count;
      logic        ready_res;
   } rsp_word_type;

   // one stored entry: tag in the top bits, key in the middle, handle low
   typedef struct packed {
      logic [15:0] model_tag;
      logic [31:0] request_key;
      logic [15:0] task_handle;
   } entry_type;

endpackage

// ----- design/cancellable_fifo_task_queue.sv -----
// ----------------------------------------------------------------------------
// cancellable_fifo_task_queue: FIFO of task entries with cancel by key
// Circular queue in a single memory, driven by a small sequencer around
// one shared slot-address unit (head plus offset, wrapped at the depth).
// ----------------------------------------------------------------------------
// One request word gives one response word. Admit, clear and any refused
// request pass from acceptance through the done state before the next word
// can be taken; select first reads the oldest entry. Revoke walks the queue
// one entry at a time (memory read, then key compare) and on a hit moves
// every younger entry up one place, one entry at a time (read, write back).
// The single memory port and the shared slot-address unit keep these steps
// sequential. The request side is stalled while a word is in work; a
// finished response sits in an output register, so the next request is
// taken while that response still waits.
// The entry memory is not cleared at reset; only data from occupied slots is used.
module cancellable_fifo_task_queue
   import cft_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam int unsigned PEND_W = $bits(rsp_word.pending_count);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEL_RD,
      S_SCAN,
      S_CHECK,
      S_MOVE_RD,
      S_MOVE_WR,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [31:0]      key_ff, key_in;
   status_type       res_status_ff, res_status_in;
   logic [15:0]      res_handle_ff, res_handle_in;
   logic [15:0]      res_tag_ff, res_tag_in;
   logic             res_cancel_ff, res_cancel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   entry_type        entry_store_ff [QUEUE_DEPTH];
   entry_type        entry_rd_ff;
   entry_type        mem_wr_data;
   logic             mem_wr_en;

   logic             req_take;
   logic [IDX_W-1:0] unit_pos;
   logic [IDX_W:0]   unit_sum;
   logic [IDX_W-1:0] unit_slot;
   logic [CNT_W-1:0] pos_next;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign pos_next  = pos_ff + CNT_W'(1);

   // pick the queue position the slot unit converts this cycle
   always_comb begin
      unique case (state_ff)
         S_IDLE:    unit_pos = (req_word.mode == MODE_ADMIT) ? count_ff[IDX_W-1:0] : '0;
         S_SEL_RD:  unit_pos = IDX_W'(1);
         S_SCAN:    unit_pos = pos_ff[IDX_W-1:0];
         S_MOVE_RD: unit_pos = pos_next[IDX_W-1:0];
         S_MOVE_WR: unit_pos = pos_ff[IDX_W-1:0];
         default:   unit_pos = '0;
      endcase
   end

   // shared slot unit: head plus position, wrapped at the depth
   assign unit_sum  = {1'b0, head_ff} + {1'b0, unit_pos};
   assign unit_slot = (unit_sum >= DEPTH_SUM) ? IDX_W'(unit_sum - DEPTH_SUM)
                                              : unit_sum[IDX_W-1:0];

   // write new entries on admit, move entries up during compaction
   assign mem_wr_en = (req_take && (req_word.mode == MODE_ADMIT) && req_word.task_present &&
                       (count_ff != DEPTH_CNT)) || (state_ff == S_MOVE_WR);
   always_comb begin
      if (state_ff == S_MOVE_WR) begin
         mem_wr_data = entry_rd_ff;
      end else begin
         mem_wr_data.model_tag   = req_word.model_tag;
         mem_wr_data.request_key = req_word.request_key;
         mem_wr_data.task_handle = req_word.task_handle;
      end
   end

   // entry memory with registered read
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         entry_store_ff[unit_slot] <= mem_wr_data;
      end
      entry_rd_ff <= entry_store_ff[unit_slot];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_tag_in    = res_tag_ff;
      res_cancel_in = res_cancel_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_status_in = STATUS_DONE;
               res_handle_in = '0;
               res_tag_in    = '0;
               res_cancel_in = 1'b0;
               key_in        = req_word.request_key;
               pos_in        = '0;
               state_in      = S_DONE;
               unique case (req_word.mode)
                  MODE_ADMIT: begin
                     if (!req_word.task_present) begin
                        res_status_in = STATUS_NO_TASK;
                     end else if (count_ff == DEPTH_CNT) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_SELECT: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_MISS;
                     end else begin
                        state_in = S_SEL_RD;
                     end
                  end
                  MODE_REVOKE: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_MISS;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SEL_RD: begin
            // pop the oldest entry
            res_handle_in = entry_rd_ff.task_handle;
            res_tag_in    = entry_rd_ff.model_tag;
            head_in       = unit_slot;
            count_in      = count_ff - CNT_W'(1);
            state_in      = S_DONE;
         end
         S_SCAN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (entry_rd_ff.request_key == key_ff) begin
               res_handle_in = entry_rd_ff.task_handle;
               if (pos_next < count_ff) begin
                  state_in = S_MOVE_RD;
               end else begin
                  res_cancel_in = 1'b1;
                  count_in      = count_ff - CNT_W'(1);
                  state_in      = S_DONE;
               end
            end else if (pos_next == count_ff) begin
               res_status_in = STATUS_MISS;
               state_in      = S_DONE;
            end else begin
               pos_in   = pos_next;
               state_in = S_SCAN;
            end
         end
         S_MOVE_RD: begin
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            // close the gap one entry at a time
            pos_in = pos_next;
            if ((pos_next + CNT_W'(1)) < count_ff) begin
               state_in = S_MOVE_RD;
            end else begin
               res_cancel_in = 1'b1;
               count_in      = count_ff - CNT_W'(1);
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.status          = res_status_ff;
               rsp_word_in.out_task_handle = res_handle_ff;
               rsp_word_in.out_model_tag   = res_tag_ff;
               rsp_word_in.cancel_signal   = res_cancel_ff;
               rsp_word_in.pending_count   = PEND_W'(count_ff);
               rsp_word_in.ready_res       = (count_ff != '0);
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_tag_ff    <= res_tag_in;
      res_cancel_ff <= res_cancel_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // occupancy never goes past the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("queue count exceeds depth");

   // a response appears only after the sequencer finished a word
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside of completion");

   // a cancel is only reported for a successful revoke
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.cancel_signal |-> rsp_word_ff.status == STATUS_DONE)
      else $error("cancel reported with failing status");

   // ready flag agrees with the pending count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.ready_res == (rsp_word_ff.pending_count != '0)))
      else $error("ready flag disagrees with pending count");

endmodule
